>>> src/i2a_pkg.sv
// shared types, constants and helper functions for the integer to ascii formatter
`timescale 1ns / 1ps

package i2a_pkg;

	// default operand width
	localparam int VALUE_BITS_DEF = 64;

	// field widths fixed by the interface
	localparam int OP_W   = 2;
	localparam int PAD_W  = 7;
	localparam int CHAR_W = 7;

	// pad widths above this saturate
	localparam logic [PAD_W-1:0] PAD_LIMIT = 7'd64;

	// ascii codes used outside the digit table
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_SDEC = 2'd0,
		OP_UDEC = 2'd1,
		OP_HEX  = 2'd2,
		OP_BIN  = 2'd3
	} op_t;

	// control from the sequencer to the bcd converter
	typedef struct packed {
		logic load;
		logic shift_digit;
	} bcd_ctrl_t;

	// status from the bcd converter
	typedef struct packed {
		logic done;
	} bcd_stat_t;

	// decimal digits needed for the largest value of a given width
	function automatic int dec_digits(input int bits);
		dec_digits = (bits * 30103) / 100000 + 1;
	endfunction

	// lowercase hex digit to ascii
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nyb);
		logic [CHAR_W-1:0] c;
		case (nyb)
			4'h0: c = 7'h30;
			4'h1: c = 7'h31;
			4'h2: c = 7'h32;
			4'h3: c = 7'h33;
			4'h4: c = 7'h34;
			4'h5: c = 7'h35;
			4'h6: c = 7'h36;
			4'h7: c = 7'h37;
			4'h8: c = 7'h38;
			4'h9: c = 7'h39;
			4'ha: c = 7'h61;
			4'hb: c = 7'h62;
			4'hc: c = 7'h63;
			4'hd: c = 7'h64;
			4'he: c = 7'h65;
			default: c = 7'h66;
		endcase
		hex_char = c;
	endfunction

endpackage

>>> src/i2a_bcd.sv
// serial binary to bcd converter, one bit per cycle, with digit shift-out
`timescale 1ns / 1ps

module i2a_bcd import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bcd_ctrl_t             ctrl,
	input  logic [VALUE_BITS-1:0] mag,
	output bcd_stat_t             stat,
	output logic [3:0]            top_digit
);

	localparam int DIGITS = dec_digits(VALUE_BITS);
	localparam int BCD_W  = 4 * DIGITS;
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;
	logic [CNT_W-1:0]      cnt_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= CNT_W'(VALUE_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// magnitude and bcd shift registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			mag_q <= mag_q << 1;
			bcd_q <= {adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
		end else if (ctrl.shift_digit) begin
			bcd_q <= bcd_q << 4;
		end
	end

	assign stat.done = (cnt_q == '0);
	assign top_digit = bcd_q[BCD_W-1 -: 4];

endmodule

>>> src/integer_to_ascii_dec_hex_bin.sv
// integer to ascii formatter: signed and unsigned decimal, padded hex and binary
//
// A request is taken on a rising edge with start high and busy low; value,
// operation and pad_width are sampled there. Characters come out most
// significant first, one per cycle from the first padding zero or digit on,
// each marked by strobe for a single cycle; last_char flags the final
// character of the request. A minus sign goes out as the request is taken,
// ahead of the conversion. The receiver cannot stall, so every character
// is taken as it appears. While busy is high a request runs these steps:
//   decimal: serial double-dabble conversion, then a scan past leading
//            zero digits, then the digits are sent
//   hex:     a scan past leading zero nybbles, then any padding zeros,
//            then the digits are sent
//   binary:  a scan past leading zero bits, then the bits are sent
// busy drops as the last character is driven; the next request can be
// taken in that cycle.
// Reset clears the sequencer and drops strobe; no request is in flight.
`timescale 1ns / 1ps

module integer_to_ascii_dec_hex_bin import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       value,
	input  logic [OP_W-1:0]   operation,
	input  logic [PAD_W-1:0]  pad_width,
	output logic              strobe,
	output logic [CHAR_W-1:0] character,
	output logic              last_char
);

	localparam int DIGITS = dec_digits(VALUE_BITS);
	localparam int DCW    = $clog2(DIGITS + 1);
	localparam int W      = 4 * ((VALUE_BITS + 3) / 4);
	localparam int CNT_W  = $clog2(W + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONVERT,
		S_DSCAN,
		S_DEMIT,
		S_HSCAN,
		S_HPAD,
		S_HEMIT,
		S_BSCAN,
		S_BEMIT
	} state_t;

	state_t            state_q;
	logic              strobe_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [W-1:0]      work_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DCW-1:0]    dcnt_q;
	logic [PAD_W-1:0]  zcnt_q;
	logic [PAD_W-1:0]  pad_q;

	logic [VALUE_BITS-1:0] v_m;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;
	logic                  accept;
	op_t                   op;
	bcd_ctrl_t             bcd_ctrl;
	bcd_stat_t             bcd_stat;
	logic [3:0]            top_digit;
	logic [PAD_W-1:0]      n7;
	logic [PAD_W-1:0]      wsat;
	logic [PAD_W-1:0]      pad_raw;
	logic [PAD_W-1:0]      zeros;

	// operand decode and magnitude
	assign op     = op_t'(operation);
	assign accept = start && (state_q == S_IDLE);
	assign v_m    = value[VALUE_BITS-1:0];
	assign neg    = (op == OP_SDEC) && v_m[VALUE_BITS-1];
	assign mag    = neg ? VALUE_BITS'(~v_m + 1'b1) : v_m;

	// converter control
	assign bcd_ctrl.load        = accept && ((op == OP_SDEC) || (op == OP_UDEC));
	assign bcd_ctrl.shift_digit = (state_q == S_DSCAN || state_q == S_DEMIT) &&
	                              !(state_q == S_DSCAN && top_digit != 4'd0);

	i2a_bcd #(
		.VALUE_BITS(VALUE_BITS)
	) u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (bcd_ctrl),
		.mag       (mag),
		.stat      (bcd_stat),
		.top_digit (top_digit)
	);

	// hex padding: leading zeros ahead of the significant nybbles
	always_comb begin
		n7      = PAD_W'(cnt_q);
		wsat    = (pad_q > PAD_LIMIT) ? PAD_LIMIT : pad_q;
		pad_raw = (wsat > n7) ? (wsat - n7) : '0;
		if (n7 > 7'd2) begin
			zeros = (pad_raw & ~7'd1) + PAD_W'(n7[0]);
		end else begin
			zeros = pad_raw;
		end
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
			work_q   <= '0;
			cnt_q    <= '0;
			dcnt_q   <= '0;
			zcnt_q   <= '0;
			pad_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pad_q <= pad_width;
						case (op)
							OP_SDEC, OP_UDEC: begin
								state_q <= S_CONVERT;
								if (neg) begin
									strobe_q <= 1'b1;
									char_q   <= CHAR_MINUS;
								end
							end
							OP_HEX: begin
								state_q <= S_HSCAN;
								work_q  <= W'(v_m);
								cnt_q   <= CNT_W'(W / 4);
							end
							default: begin
								state_q <= S_BSCAN;
								work_q  <= W'(v_m) << (W - VALUE_BITS);
								cnt_q   <= CNT_W'(VALUE_BITS);
							end
						endcase
					end
				end
				S_CONVERT: begin
					if (bcd_stat.done) begin
						state_q <= S_DSCAN;
						dcnt_q  <= DCW'(DIGITS);
					end
				end
				S_DSCAN: begin
					if (top_digit == 4'd0 && dcnt_q > DCW'(1)) begin
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						state_q <= S_DEMIT;
					end
				end
				S_DEMIT: begin
					strobe_q <= 1'b1;
					char_q   <= CHAR_ZERO + CHAR_W'(top_digit);
					last_q   <= (dcnt_q == DCW'(1));
					dcnt_q   <= dcnt_q - 1'b1;
					if (dcnt_q == DCW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_HSCAN: begin
					if (work_q[W-1 -: 4] == 4'd0 && cnt_q > CNT_W'(1)) begin
						work_q <= work_q << 4;
						cnt_q  <= cnt_q - 1'b1;
					end else begin
						zcnt_q  <= zeros;
						state_q <= (zeros != '0) ? S_HPAD : S_HEMIT;
					end
				end
				S_HPAD: begin
					strobe_q <= 1'b1;
					char_q   <= CHAR_ZERO;
					zcnt_q   <= zcnt_q - 1'b1;
					if (zcnt_q == 7'd1) begin
						state_q <= S_HEMIT;
					end
				end
				S_HEMIT: begin
					strobe_q <= 1'b1;
					char_q   <= hex_char(work_q[W-1 -: 4]);
					last_q   <= (cnt_q == CNT_W'(1));
					work_q   <= work_q << 4;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_BSCAN: begin
					if (!work_q[W-1] && cnt_q > CNT_W'(1)) begin
						work_q <= work_q << 1;
						cnt_q  <= cnt_q - 1'b1;
					end else begin
						state_q <= S_BEMIT;
					end
				end
				S_BEMIT: begin
					strobe_q <= 1'b1;
					char_q   <= CHAR_ZERO + CHAR_W'(work_q[W-1]);
					last_q   <= (cnt_q == CNT_W'(1));
					work_q   <= work_q << 1;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign character = char_q;
	assign last_char = last_q;

	// the final character of a request leaves exactly as the block goes idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last_char == !busy))
		else $error("last_char out of step with busy");

	// an accepted request always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");

	// digit emission never runs with an empty count
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HEMIT || state_q == S_BEMIT) |-> (cnt_q != '0))
		else $error("digit count exhausted while emitting");

	// padding never runs with an empty count
	a_pad_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HPAD) |-> (zcnt_q != '0))
		else $error("pad count exhausted while padding");

	// decimal digits are only read once the converter has finished
	a_bcd_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DSCAN || state_q == S_DEMIT) |-> bcd_stat.done)
		else $error("decimal digits read before conversion finished");

endmodule
